[design/dws_pkg.sv]
// dws_pkg: shared constants and codes for the deque with top swap
// operation codes, status codes and fixed field widths
// no dependencies
package dws_pkg;

    localparam int VAL_IN_W = 32;
    localparam int RANK_W   = 9;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_SWAP      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

[design/dws_ram.sv]
// dws_ram: entry store of the deque, one write port and one read port
// read data registered, no reset on the array
// no dependencies
module dws_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 41,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/deque_with_top_swap.sv]
// deque_with_top_swap: bounded double-ended queue in a ring buffer with head swap
// depends on dws_pkg and dws_ram
//
//   channel  handshake                 beat fields
//   input    i_in_valid / o_in_stall   i_op, i_entry_value, i_entry_rank
//   output   o_out_valid / i_out_stall o_status, o_out_value, o_out_rank
//
// one item at a time; push, failed ops and unused codes pass through S_FIN, pops
// through S_POP, swap through S_SWAPA, S_SWAPB and S_SWAPC (two reads and two
// writes through the single port pair of the entry store)
// a result waits in the output register while the next item is accepted;
// if that register is still held by a stall, the new result parks in a hold state
// synchronous active-low reset clears pointers, count and control; the store is not cleared
module deque_with_top_swap #(
    parameter int DEPTH       = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dws_pkg::OP_W-1:0]            i_op,
    input  logic signed [dws_pkg::VAL_IN_W-1:0] i_entry_value,
    input  logic [dws_pkg::RANK_W-1:0]          i_entry_rank,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dws_pkg::STATUS_W-1:0]        o_status,
    output logic signed [dws_pkg::VAL_IN_W-1:0] o_out_value,
    output logic [dws_pkg::RANK_W-1:0]          o_out_rank
);
    import dws_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = VALUE_WIDTH + RANK_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POP   = 6'b000010,
        S_SWAPA = 6'b000100,
        S_SWAPB = 6'b001000,
        S_SWAPC = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_addr_a, n_addr_a;
    logic [PW-1:0] r_addr_b, n_addr_b;
    logic [EW-1:0] r_tmp, n_tmp;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VAL_IN_W-1:0] r_value, n_value;
    logic [RANK_W-1:0]   r_rank, n_rank;

    logic [STATUS_W-1:0] r_p_status, n_p_status;
    logic [VAL_IN_W-1:0] r_p_value, n_p_value;
    logic [RANK_W-1:0]   r_p_rank, n_p_rank;

    logic                accept;
    logic                out_free;
    logic [SW-1:0]       tail_sum, last_sum;
    logic [PW-1:0]       tail_pos, last_pos, head_inc, head_dec;
    logic [63:0]         in_ext;
    logic [63:0]         rd_ext;
    logic [EW-1:0]       wr_data, mem_wr_data, rd_data;
    logic [VAL_IN_W-1:0] rd_value;
    logic                mem_wr_en, mem_rd_en;
    logic [PW-1:0]       mem_wr_addr, mem_rd_addr;

    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [VAL_IN_W-1:0] fin_value;
    logic [RANK_W-1:0]   fin_rank;

    dws_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (EW),
        .ADDR_W (PW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // ring arithmetic, sums stay below twice the depth while the deque is not empty
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign last_sum = SW'(r_head) + SW'(r_count - CW'(1));
    assign tail_pos = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);
    assign last_pos = (last_sum >= SW'(DEPTH)) ? PW'(last_sum - SW'(DEPTH)) : PW'(last_sum);
    assign head_inc = (r_head == PW'(DEPTH - 1)) ? '0 : r_head + PW'(1);
    assign head_dec = (r_head == '0) ? PW'(DEPTH - 1) : r_head - PW'(1);

    assign in_ext   = {{32{i_entry_value[VAL_IN_W-1]}}, i_entry_value};
    assign wr_data  = {in_ext[VALUE_WIDTH-1:0], i_entry_rank};
    assign rd_ext   = 64'(rd_data[EW-1:RANK_W]);
    assign rd_value = rd_ext[VAL_IN_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_addr_a    = r_addr_a;
        n_addr_b    = r_addr_b;
        n_tmp       = r_tmp;
        n_p_status  = r_p_status;
        n_p_value   = r_p_value;
        n_p_rank    = r_p_rank;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr_a;
        mem_wr_data = wr_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_head;
        fin         = 1'b0;
        fin_status  = ST_DONE;
        fin_value   = '0;
        fin_rank    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_p_status = ST_DONE;
                    n_p_value  = '0;
                    n_p_rank   = '0;
                    n_state    = S_FIN;
                    case (t_op'(i_op))
                        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_p_status = ST_FULL;
                            end else begin
                                mem_wr_en = 1'b1;
                                n_count   = r_count + CW'(1);
                                if (t_op'(i_op) == OP_PUSH_HEAD) begin
                                    mem_wr_addr = head_dec;
                                    n_head      = head_dec;
                                end else begin
                                    mem_wr_addr = tail_pos;
                                end
                            end
                        end
                        OP_POP_HEAD, OP_POP_TAIL: begin
                            if (r_count == '0) begin
                                n_p_status = ST_SHORT;
                            end else begin
                                mem_rd_en = 1'b1;
                                n_count   = r_count - CW'(1);
                                n_state   = S_POP;
                                if (t_op'(i_op) == OP_POP_HEAD) begin
                                    mem_rd_addr = r_head;
                                    n_head      = head_inc;
                                end else begin
                                    mem_rd_addr = last_pos;
                                end
                            end
                        end
                        OP_SWAP: begin
                            if (r_count < CW'(2)) begin
                                n_p_status = ST_SHORT;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = r_head;
                                n_addr_a    = r_head;
                                n_addr_b    = head_inc;
                                n_state     = S_SWAPA;
                            end
                        end
                        default: begin
                            n_p_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_POP: begin
                fin       = 1'b1;
                fin_value = rd_value;
                fin_rank  = rd_data[RANK_W-1:0];
            end
            S_SWAPA: begin
                n_tmp       = rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_addr_b;
                n_state     = S_SWAPB;
            end
            S_SWAPB: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_addr_a;
                mem_wr_data = rd_data;
                n_state     = S_SWAPC;
            end
            S_SWAPC: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_addr_b;
                mem_wr_data = r_tmp;
                fin         = 1'b1;
            end
            S_FIN: begin
                fin        = 1'b1;
                fin_status = r_p_status;
                fin_value  = r_p_value;
                fin_rank   = r_p_rank;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result goes out now, or parks until the output register frees
        if (fin) begin
            if (out_free) begin
                n_state = S_IDLE;
            end else begin
                n_p_status = fin_status;
                n_p_value  = fin_value;
                n_p_rank   = fin_rank;
                n_state    = S_FIN;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value     = r_value;
        n_rank      = r_rank;
        if (fin && out_free) begin
            n_out_valid = 1'b1;
            n_status    = fin_status;
            n_value     = fin_value;
            n_rank      = fin_rank;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr_a   <= n_addr_a;
        r_addr_b   <= n_addr_b;
        r_tmp      <= n_tmp;
        r_p_status <= n_p_status;
        r_p_value  <= n_p_value;
        r_p_rank   <= n_p_rank;
        r_status   <= n_status;
        r_value    <= n_value;
        r_rank     <= n_rank;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_value = r_value;
    assign o_out_rank  = r_rank;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= PW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted beat left no work in flight");

    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAPC) |-> ($past(r_state) == S_SWAPB))
        else $error("swap write-back out of order");

endmodule
